// File: sv/dpbt_pkg.sv
// ----------------------------------------------------------------------------
// dpbt_pkg: shared definitions for the dirty page bitmap tracker
// Widths, address splits, operation codes and the lowest-set-bit encoder.
// ----------------------------------------------------------------------------
package dpbt_pkg;

  // Word and address geometry
  localparam int WORD_BITS   = 64;
  localparam int NUM_PAGES   = 262144;
  localparam int PAGE_W      = 18;                    // page index width
  localparam int BIT_W       = 6;                     // bit within a word
  localparam int LEAF_IDX_W  = PAGE_W - BIT_W;        // leaf word index
  localparam int SUM_IDX_W   = LEAF_IDX_W - BIT_W;    // summary word index
  localparam int LEAF_ADDR_W = LEAF_IDX_W + 1;        // bank bit on top
  localparam int SUM_ADDR_W  = SUM_IDX_W + 1;
  localparam int CAP_W       = 19;
  localparam int CNT_W       = 7;

  localparam logic [CAP_W-1:0] CAP_RESET  = CAP_W'(NUM_PAGES);
  localparam logic [CNT_W-1:0] SCAN_LIMIT = CNT_W'(64);

  // Operation codes
  localparam logic [1:0] FN_MARK      = 2'd0;
  localparam logic [1:0] FN_SCAN_ACT  = 2'd1;
  localparam logic [1:0] FN_SCAN_CHK  = 2'd2;
  localparam logic [1:0] FN_SWAP      = 2'd3;

  typedef logic [WORD_BITS-1:0] word_t;

  // Index of the lowest set bit; zero when the word is empty
  function automatic logic [BIT_W-1:0] low_bit(input word_t v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

endpackage

// File: sv/dirty_page_bitmap_tracker_top.sv
// ----------------------------------------------------------------------------
// dirty_page_bitmap_tracker_top: two-bank hierarchical dirty page bitmap
// Marks set page bits in the active bank; scans report set pages in order.
// ----------------------------------------------------------------------------
//
//  channel  | handshake              | beat contents
//  ---------+------------------------+------------------------------------------
//  in       | in_valid / in_ready    | func, page_index, max_out
//  out      | out_valid / out_ready  | dirty_page, page_valid, last, returned_count
//  cfg      | cfg_we (no wait)       | cfg_wdata -> capacity (grows only)
//
//  Mark reads the leaf and summary words, then writes them back.
//  A scan walks the occupied summary words, then their occupied leaf words,
//  then the pages, through the single read port of each memory; the page
//  limit or the capacity bound ends it early.
//  Reset clears the two 64-bit top words, which hide all stale memory
//  contents; no clearing pass is needed. Swap clears one top word.
//  A stalled output holds the scan; input is taken only when idle.
// ----------------------------------------------------------------------------
module dirty_page_bitmap_tracker_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    func,
  input  logic [dpbt_pkg::PAGE_W-1:0]   page_index,
  input  logic [dpbt_pkg::CNT_W-1:0]    max_out,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dpbt_pkg::PAGE_W-1:0]   dirty_page,
  output logic                          page_valid,
  output logic                          last,
  output logic [dpbt_pkg::CNT_W-1:0]    returned_count,
  input  logic                          cfg_we,
  input  logic [dpbt_pkg::CAP_W-1:0]    cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE, S_MARK, S_TOP, S_SUMRD, S_SUM, S_LEAFRD, S_LEAF, S_FIN
  } state_t;

  state_t state;

  // Control and datapath registers
  logic                              act;
  logic                              bank;
  dpbt_pkg::word_t                   top_q [2];
  logic [dpbt_pkg::CAP_W-1:0]        capacity;
  logic [dpbt_pkg::CNT_W-1:0]        limit;
  logic [dpbt_pkg::CNT_W-1:0]        cnt;
  dpbt_pkg::word_t                   top_rem;
  dpbt_pkg::word_t                   sum_rem;
  dpbt_pkg::word_t                   leaf_rem;
  logic [dpbt_pkg::SUM_IDX_W-1:0]    s_idx;
  logic [dpbt_pkg::BIT_W-1:0]        wl_idx;
  logic [dpbt_pkg::PAGE_W-1:0]       page_q;
  logic                              pend_valid;
  logic [dpbt_pkg::PAGE_W-1:0]       pend_page;

  // Memories: both banks share one array, bank selects the top address bit
  dpbt_pkg::word_t leaf_mem [2**dpbt_pkg::LEAF_ADDR_W];
  dpbt_pkg::word_t sum_mem  [2**dpbt_pkg::SUM_ADDR_W];
  dpbt_pkg::word_t leaf_rd;
  dpbt_pkg::word_t sum_rd;

  logic                               leaf_re, leaf_we, sum_re, sum_we;
  logic [dpbt_pkg::LEAF_ADDR_W-1:0]   leaf_raddr, leaf_waddr;
  logic [dpbt_pkg::SUM_ADDR_W-1:0]    sum_raddr, sum_waddr;
  dpbt_pkg::word_t                    leaf_wdata, sum_wdata;

  // Decoded helpers
  logic                               accept;
  logic                               out_free;
  logic [dpbt_pkg::CNT_W-1:0]         limit_in;
  logic [dpbt_pkg::CNT_W-1:0]         cnt_inc;
  logic [dpbt_pkg::BIT_W-1:0]         top_low, sum_low, leaf_low;
  logic [dpbt_pkg::PAGE_W-1:0]        found_page;
  logic                               cap_hit;
  logic                               beat_load;
  logic [dpbt_pkg::SUM_IDX_W-1:0]     mk_s;
  logic [dpbt_pkg::BIT_W-1:0]         mk_wl;
  logic [dpbt_pkg::BIT_W-1:0]         mk_b;
  dpbt_pkg::word_t                    mk_sum_eff, mk_leaf_eff;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign limit_in = (max_out > dpbt_pkg::SCAN_LIMIT) ? dpbt_pkg::SCAN_LIMIT : max_out;
  assign cnt_inc  = cnt + 1'b1;

  assign top_low    = dpbt_pkg::low_bit(top_rem);
  assign sum_low    = dpbt_pkg::low_bit(sum_rem);
  assign leaf_low   = dpbt_pkg::low_bit(leaf_rem);
  assign found_page = {s_idx, wl_idx, leaf_low};
  assign cap_hit    = ({1'b0, found_page} >= capacity);

  // An output beat is loaded this cycle (held page pushed out, or closing beat)
  assign beat_load = out_free &&
                     ((state == S_LEAF && leaf_rem != '0 && !cap_hit && pend_valid) ||
                      state == S_FIN);

  // Mark read-modify-write: a clear top bit hides a stale summary word,
  // a clear summary bit hides a stale leaf word
  assign mk_s        = page_q[dpbt_pkg::PAGE_W-1 -: dpbt_pkg::SUM_IDX_W];
  assign mk_wl       = page_q[2*dpbt_pkg::BIT_W-1 -: dpbt_pkg::BIT_W];
  assign mk_b        = page_q[dpbt_pkg::BIT_W-1:0];
  assign mk_sum_eff  = top_q[act][mk_s] ? sum_rd : '0;
  assign mk_leaf_eff = mk_sum_eff[mk_wl] ? leaf_rd : '0;

  // Memory port control
  always_comb begin
    leaf_re    = 1'b0;
    sum_re     = 1'b0;
    leaf_raddr = {bank, s_idx, sum_low};
    sum_raddr  = {bank, top_low};
    leaf_we    = (state == S_MARK);
    sum_we     = (state == S_MARK);
    leaf_waddr = {act, page_q[dpbt_pkg::PAGE_W-1:dpbt_pkg::BIT_W]};
    sum_waddr  = {act, mk_s};
    leaf_wdata = mk_leaf_eff | (dpbt_pkg::word_t'(1) << mk_b);
    sum_wdata  = mk_sum_eff | (dpbt_pkg::word_t'(1) << mk_wl);
    if (accept && func == dpbt_pkg::FN_MARK) begin
      leaf_re    = 1'b1;
      sum_re     = 1'b1;
      leaf_raddr = {act, page_index[dpbt_pkg::PAGE_W-1:dpbt_pkg::BIT_W]};
      sum_raddr  = {act, page_index[dpbt_pkg::PAGE_W-1 -: dpbt_pkg::SUM_IDX_W]};
    end else if (state == S_TOP) begin
      sum_re = (top_rem != '0);
    end else if (state == S_SUM) begin
      leaf_re = (sum_rem != '0);
    end
  end

  // Leaf memory
  always_ff @(posedge clk) begin
    if (leaf_we) leaf_mem[leaf_waddr] <= leaf_wdata;
    if (leaf_re) leaf_rd <= leaf_mem[leaf_raddr];
  end

  // Summary memory
  always_ff @(posedge clk) begin
    if (sum_we) sum_mem[sum_waddr] <= sum_wdata;
    if (sum_re) sum_rd <= sum_mem[sum_raddr];
  end

  // Sequencer with registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      act        <= 1'b0;
      top_q[0]   <= '0;
      top_q[1]   <= '0;
      capacity   <= dpbt_pkg::CAP_RESET;
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      // capacity only grows
      if (cfg_we && cfg_wdata > capacity) capacity <= cfg_wdata;
      if (out_valid && out_ready && !beat_load) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            unique case (func)
              dpbt_pkg::FN_MARK: begin
                page_q <= page_index;
                state  <= S_MARK;
              end
              dpbt_pkg::FN_SCAN_ACT, dpbt_pkg::FN_SCAN_CHK: begin
                bank       <= (func == dpbt_pkg::FN_SCAN_ACT) ? act : ~act;
                top_rem    <= (func == dpbt_pkg::FN_SCAN_ACT) ? top_q[act] : top_q[~act];
                limit      <= limit_in;
                cnt        <= '0;
                pend_valid <= 1'b0;
                state      <= (limit_in == '0) ? S_FIN : S_TOP;
              end
              dpbt_pkg::FN_SWAP: begin
                act        <= ~act;
                top_q[~act] <= '0;
              end
            endcase
          end
        end

        S_MARK: begin
          top_q[act] <= top_q[act] | (dpbt_pkg::word_t'(1) << mk_s);
          state      <= S_IDLE;
        end

        // next occupied summary word
        S_TOP: begin
          if (top_rem == '0) begin
            state <= S_FIN;
          end else begin
            s_idx   <= top_low;
            top_rem <= top_rem & (top_rem - 1'b1);
            state   <= S_SUMRD;
          end
        end

        S_SUMRD: begin
          sum_rem <= sum_rd;
          state   <= S_SUM;
        end

        // next occupied leaf word
        S_SUM: begin
          if (sum_rem == '0) begin
            state <= S_TOP;
          end else begin
            wl_idx  <= sum_low;
            sum_rem <= sum_rem & (sum_rem - 1'b1);
            state   <= S_LEAFRD;
          end
        end

        S_LEAFRD: begin
          leaf_rem <= leaf_rd;
          state    <= S_LEAF;
        end

        // one page per cycle unless the output stalls with a page held; the previous find is sent once a new one exists
        S_LEAF: begin
          if (leaf_rem == '0) begin
            state <= S_SUM;
          end else if (cap_hit) begin
            state <= S_FIN;
          end else if (!pend_valid || out_free) begin
            if (pend_valid) begin
              out_valid      <= 1'b1;
              dirty_page     <= pend_page;
              page_valid     <= 1'b1;
              last           <= 1'b0;
              returned_count <= '0;
            end
            pend_valid <= 1'b1;
            pend_page  <= found_page;
            cnt        <= cnt_inc;
            leaf_rem   <= leaf_rem & (leaf_rem - 1'b1);
            if (cnt_inc == limit) state <= S_FIN;
          end
        end

        // closing beat: held page with count, or the empty marker
        S_FIN: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            dirty_page     <= pend_valid ? pend_page : '0;
            page_valid     <= pend_valid;
            last           <= 1'b1;
            returned_count <= pend_valid ? cnt : '0;
            pend_valid     <= 1'b0;
            state          <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_cnt_bounded: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE && state != S_MARK) |-> cnt <= limit)
    else $error("scan count above limit");

  a_mid_has_page: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> page_valid)
    else $error("non-final beat without a page");

  a_last_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last && page_valid) |-> returned_count != '0)
    else $error("final page beat with zero count");

  a_pend_count: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> cnt != '0)
    else $error("held page without count");

  a_swap_clears: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(in_valid && in_ready && func == dpbt_pkg::FN_SWAP))
      |-> top_q[act] == '0)
    else $error("new active bank not cleared after swap");

endmodule
